[rtl/ttgc_pkg.sv]
package ttgc_pkg;

    localparam int UID_W        = 56;
    localparam int UID_LEN_W    = 3;
    localparam int TIME_W       = 32;
    localparam int MS_W         = 16;
    localparam int UID_BYTES_DEF = 7;
    localparam int UID_SLOTS    = UID_W / 8;

    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [MS_W-1:0] TAP_WINDOW_RST = 16'd500;
    localparam logic [MS_W-1:0] HOLD_THR_RST   = 16'd3000;
    localparam logic [MS_W-1:0] SAMPLE_GAP_RST = 16'd100;

    localparam logic [7:0] TALLY_MAX = 8'd255;

    typedef enum logic [1:0]
    {
        REG_ENABLE     = 2'd0,
        REG_TAP_WINDOW = 2'd1,
        REG_HOLD_THR   = 2'd2,
        REG_SAMPLE_GAP = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        GEST_NONE   = 3'd0,
        GEST_SINGLE = 3'd1,
        GEST_DOUBLE = 3'd2,
        GEST_TRIPLE = 3'd3,
        GEST_LONG   = 3'd4
    } gesture_t;

    typedef struct packed
    {
        logic            enable;
        logic [MS_W-1:0] tap_window_ms;
        logic [MS_W-1:0] hold_threshold_ms;
        logic [MS_W-1:0] sample_gap_ms;
    } cfg_t;

    typedef struct packed
    {
        logic                 func;
        logic [TIME_W-1:0]    now_ms;
        logic                 tag_seen;
        logic [UID_W-1:0]     tag_uid;
        logic [UID_LEN_W-1:0] tag_uid_len;
    } item_t;

    typedef struct packed
    {
        logic [UID_LEN_W-1:0] held_uid_len;
        logic [UID_W-1:0]     held_uid;
        logic                 sample_accepted;
        logic                 present_now;
        gesture_t             gesture;
    } result_t;

endpackage

[rtl/ttgc_regs.sv]
module ttgc_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ttgc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ttgc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ttgc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output ttgc_pkg::cfg_t                   cfg
);
    import ttgc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.tap_window_ms     <= TAP_WINDOW_RST;
            cfg_reg.hold_threshold_ms <= HOLD_THR_RST;
            cfg_reg.sample_gap_ms     <= SAMPLE_GAP_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ENABLE:     cfg_reg.enable            <= pwdata[0];
                REG_TAP_WINDOW: cfg_reg.tap_window_ms     <= pwdata[MS_W-1:0];
                REG_HOLD_THR:   cfg_reg.hold_threshold_ms <= pwdata[MS_W-1:0];
                REG_SAMPLE_GAP: cfg_reg.sample_gap_ms     <= pwdata[MS_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_ENABLE:     prdata[0]        = cfg_reg.enable;
            REG_TAP_WINDOW: prdata[MS_W-1:0] = cfg_reg.tap_window_ms;
            REG_HOLD_THR:   prdata[MS_W-1:0] = cfg_reg.hold_threshold_ms;
            REG_SAMPLE_GAP: prdata[MS_W-1:0] = cfg_reg.sample_gap_ms;
            default:        prdata = '0;
        endcase
    end

endmodule

[rtl/ttgc_core.sv]
module ttgc_core
#(
    parameter int UID_BYTES = ttgc_pkg::UID_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  ttgc_pkg::cfg_t    cfg,
    input  ttgc_pkg::item_t   item,
    output ttgc_pkg::result_t result
);
    import ttgc_pkg::*;

    localparam int LEN_CAP = (UID_BYTES < UID_SLOTS) ? UID_BYTES : UID_SLOTS;
    localparam logic [UID_LEN_W-1:0] LEN_CAP_V = UID_LEN_W'(LEN_CAP);

    gesture_t             pend_reg, pend_next;
    logic [7:0]           tally_reg, tally_next;
    logic [TIME_W-1:0]    first_reg, first_next;
    logic [TIME_W-1:0]    hold_reg, hold_next;
    logic                 present_reg, present_next;
    logic [TIME_W-1:0]    last_reg, last_next;
    logic [UID_W-1:0]     uid_reg, uid_next;
    logic [UID_LEN_W-1:0] len_reg, len_next;

    always_comb
    begin
        logic [UID_LEN_W-1:0] n;
        logic                 acc;
        logic [7:0]           tally_inc;
        gesture_t             g;
        pend_next    = pend_reg;
        tally_next   = tally_reg;
        first_next   = first_reg;
        hold_next    = hold_reg;
        present_next = present_reg;
        last_next    = last_reg;
        uid_next     = uid_reg;
        len_next     = len_reg;
        acc          = 1'b0;
        g            = pend_reg;
        n            = (item.tag_uid_len > LEN_CAP_V) ? LEN_CAP_V : item.tag_uid_len;
        tally_inc    = (tally_reg < TALLY_MAX) ? tally_reg + 8'd1 : tally_reg;

        if (item.func)
        begin
            pend_next = GEST_NONE;
        end
        else if (cfg.enable &&
                 ((item.now_ms - last_reg) >= {{(TIME_W-MS_W){1'b0}}, cfg.sample_gap_ms}))
        begin
            acc          = 1'b1;
            last_next    = item.now_ms;
            present_next = item.tag_seen;
            if (item.tag_seen)
            begin
                for (int i = 0; i < UID_SLOTS; i++)
                begin
                    if (UID_LEN_W'(i) < n)
                        uid_next[8*i +: 8] = item.tag_uid[8*i +: 8];
                end
                len_next = n;
                if (!present_reg)
                begin
                    hold_next  = item.now_ms;
                    tally_next = tally_inc;
                    if (tally_inc == 8'd1)
                        first_next = item.now_ms;
                end
                if (((item.now_ms - hold_next) >= {{(TIME_W-MS_W){1'b0}},
                      cfg.hold_threshold_ms}) && (pend_reg != GEST_LONG))
                begin
                    pend_next  = GEST_LONG;
                    tally_next = 8'd0;
                end
            end
            else if ((tally_reg != 8'd0) &&
                     ((item.now_ms - first_reg) > {{(TIME_W-MS_W){1'b0}}, cfg.tap_window_ms}))
            begin
                if (pend_reg != GEST_LONG)
                begin
                    priority if (tally_reg == 8'd1)
                        pend_next = GEST_SINGLE;
                    else if (tally_reg == 8'd2)
                        pend_next = GEST_DOUBLE;
                    else
                        pend_next = GEST_TRIPLE;
                end
                tally_next = 8'd0;
            end
            g = pend_next;
        end

        result.gesture         = g;
        result.present_now     = present_next;
        result.sample_accepted = acc;
        result.held_uid        = uid_next;
        result.held_uid_len    = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= GEST_NONE;
            tally_reg   <= '0;
            first_reg   <= '0;
            hold_reg    <= '0;
            present_reg <= 1'b0;
            last_reg    <= '0;
            uid_reg     <= '0;
            len_reg     <= '0;
        end
        else if (step)
        begin
            pend_reg    <= pend_next;
            tally_reg   <= tally_next;
            first_reg   <= first_next;
            hold_reg    <= hold_next;
            present_reg <= present_next;
            last_reg    <= last_next;
            uid_reg     <= uid_next;
            len_reg     <= len_next;
        end
    end

endmodule

[rtl/tag_tap_gesture_classifier_top.sv]
// Tap / long-hold gesture classifier for tag presence samples.
// Input stream (s_*): one request per sample or consume. s_tuser is the
// function (0 presence sample, 1 consume pending gesture); s_tdata carries
// timestamp, seen flag, UID and UID length.
// Output stream (m_*): exactly one result per request, in order, with the
// gesture, presence, sample-accepted flag and latched UID.
// APB port: enable, tap window, hold threshold and sample gap registers at
// byte offsets 0x0, 0x4, 0x8, 0xC; write only while the stream is idle.
// The result passes through the input register, then the result register,
// before m_tvalid rises. Throughput: one request per cycle while m_tready
// is high; the state update is a single pass of compares and subtractions
// from the input register.
// Reset: gesture state, timers and UID store clear; registers take defaults.
// Stall: while a result waits with m_tready low, the result register holds,
// the input register fills, and s_tready drops until the result is taken.
module tag_tap_gesture_classifier_top
#(
    parameter int UID_BYTES = ttgc_pkg::UID_BYTES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_ms[31:0], tag_seen[32], tag_uid[88:33], tag_uid_len[91:89], zero pad
    input  logic [95:0]                      s_tdata,
    // func
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // gesture[2:0], present_now[3], sample_accepted[4], held_uid[60:5],
    // held_uid_len[63:61]
    output logic [63:0]                      m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ttgc_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ttgc_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ttgc_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ttgc_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_vld_reg;
    result_t res;
    result_t out_reg;
    logic    out_vld_reg;
    logic    adv;

    assign adv      = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    ttgc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ttgc_core #(.UID_BYTES(UID_BYTES)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (adv),
        .cfg    (cfg),
        .item   (in_reg),
        .result (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (adv)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.func        <= s_tuser;
            in_reg.now_ms      <= s_tdata[31:0];
            in_reg.tag_seen    <= s_tdata[32];
            in_reg.tag_uid     <= s_tdata[88:33];
            in_reg.tag_uid_len <= s_tdata[91:89];
        end
        if (adv)
            out_reg <= res;
    end

endmodule
